### hw/rtl/delta_zigzag_varint_encoder_top_assert.svh
// Assertion macros shared by the encoder modules.
`ifndef DELTA_ZIGZAG_VARINT_ENCODER_TOP_ASSERT_SVH
`define DELTA_ZIGZAG_VARINT_ENCODER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DZV_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DZV_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/dzv_pkg.sv
package dzv_pkg;

    localparam int WordW     = 64;
    localparam int DigitW    = 8;
    localparam int NumDigits = WordW / DigitW;
    localparam int CntW      = $clog2(NumDigits);
    localparam int GroupW    = 7;
    localparam int ByteW     = 8;

    typedef enum logic [1:0] {
        SUB_IDLE,
        SUB_RUN,
        SUB_HOLD
    } sub_state_t;

    typedef struct packed {
        logic [WordW-1:0] data;
        logic             last;
    } diff_beat_t;

endpackage

### hw/rtl/dzv_delta.sv
`include "delta_zigzag_varint_encoder_top_assert.svh"

module dzv_delta
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [dzv_pkg::WordW-1:0]     in_word,
    input  logic                          in_last,
    output logic                          diff_valid,
    input  logic                          diff_ready,
    output dzv_pkg::diff_beat_t           diff_beat
);

    dzv_pkg::sub_state_t               state_reg;
    dzv_pkg::sub_state_t               state_next;
    logic [dzv_pkg::CntW-1:0]          cnt_reg;
    logic                              carry_reg;
    logic [dzv_pkg::WordW-1:0]         prev_reg;
    logic [dzv_pkg::WordW-1:0]         a_reg;
    logic [dzv_pkg::WordW-1:0]         b_reg;
    logic [dzv_pkg::WordW-1:0]         d_reg;
    logic                              last_reg;
    logic [dzv_pkg::DigitW:0]          sum;
    logic                              in_fire;
    logic                              cnt_end;

    assign in_ready = (state_reg == dzv_pkg::SUB_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign cnt_end  = (cnt_reg == dzv_pkg::CntW'(dzv_pkg::NumDigits - 1));

    // Subtraction as addition of the inverted digit with a running carry.
    assign sum = {1'b0, a_reg[dzv_pkg::DigitW-1:0]}
               + {1'b0, ~b_reg[dzv_pkg::DigitW-1:0]}
               + {{dzv_pkg::DigitW{1'b0}}, carry_reg};

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            dzv_pkg::SUB_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = dzv_pkg::SUB_RUN;
                end
            end
            dzv_pkg::SUB_RUN:
            begin
                if (cnt_end)
                begin
                    state_next = dzv_pkg::SUB_HOLD;
                end
            end
            dzv_pkg::SUB_HOLD:
            begin
                if (diff_ready)
                begin
                    state_next = dzv_pkg::SUB_IDLE;
                end
            end
            default:
            begin
                state_next = dzv_pkg::SUB_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dzv_pkg::SUB_IDLE;
            cnt_reg   <= '0;
            carry_reg <= 1'b1;
            prev_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (in_fire)
            begin
                cnt_reg   <= '0;
                carry_reg <= 1'b1;
                prev_reg  <= in_last ? '0 : in_word;
            end
            else if (state_reg == dzv_pkg::SUB_RUN)
            begin
                cnt_reg   <= cnt_reg + dzv_pkg::CntW'(1);
                carry_reg <= sum[dzv_pkg::DigitW];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            a_reg    <= in_word;
            b_reg    <= prev_reg;
            last_reg <= in_last;
        end
        else if (state_reg == dzv_pkg::SUB_RUN)
        begin
            a_reg <= {{dzv_pkg::DigitW{1'b0}}, a_reg[dzv_pkg::WordW-1:dzv_pkg::DigitW]};
            b_reg <= {{dzv_pkg::DigitW{1'b0}}, b_reg[dzv_pkg::WordW-1:dzv_pkg::DigitW]};
            d_reg <= {sum[dzv_pkg::DigitW-1:0], d_reg[dzv_pkg::WordW-1:dzv_pkg::DigitW]};
        end
    end

    assign diff_valid     = (state_reg == dzv_pkg::SUB_HOLD);
    assign diff_beat.data = d_reg;
    assign diff_beat.last = last_reg;

    `DZV_ASSERT_NEXT(a_fire_starts_run, clk, rst_n, in_fire,
        state_reg == dzv_pkg::SUB_RUN, "accepted word did not start subtraction")
    `DZV_ASSERT_SAME(a_run_count_zero_on_entry, clk, rst_n,
        (state_reg == dzv_pkg::SUB_RUN) && ($past(state_reg) == dzv_pkg::SUB_IDLE),
        (cnt_reg == '0) && carry_reg, "subtraction did not start at the low digit")
    `DZV_ASSERT_NEXT(a_handoff_frees, clk, rst_n, diff_valid && diff_ready,
        state_reg == dzv_pkg::SUB_IDLE, "difference handed off but stage not freed")

endmodule

### hw/rtl/dzv_emit.sv
`include "delta_zigzag_varint_encoder_top_assert.svh"

module dzv_emit
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          diff_valid,
    output logic                          diff_ready,
    input  dzv_pkg::diff_beat_t           diff_beat,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [dzv_pkg::ByteW-1:0]     out_byte,
    output logic                          out_word_done,
    output logic                          out_block_done
);

    logic                              busy_reg;
    logic [dzv_pkg::WordW-1:0]         z_reg;
    logic                              last_reg;
    logic                              ov_reg;
    logic [dzv_pkg::ByteW-1:0]         byte_reg;
    logic                              wd_reg;
    logic                              bd_reg;
    logic [dzv_pkg::WordW-1:0]         zig;
    logic                              more;
    logic                              load;
    logic                              step;

    assign zig = {diff_beat.data[dzv_pkg::WordW-2:0], 1'b0}
               ^ {dzv_pkg::WordW{diff_beat.data[dzv_pkg::WordW-1]}};

    assign more       = |z_reg[dzv_pkg::WordW-1:dzv_pkg::GroupW];
    assign diff_ready = !busy_reg;
    assign load       = diff_valid && !busy_reg;
    assign step       = busy_reg && (!ov_reg || out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            ov_reg   <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                busy_reg <= 1'b1;
            end
            else if (step && !more)
            begin
                busy_reg <= 1'b0;
            end
            if (step)
            begin
                ov_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            z_reg    <= zig;
            last_reg <= diff_beat.last;
        end
        else if (step)
        begin
            z_reg <= {{dzv_pkg::GroupW{1'b0}}, z_reg[dzv_pkg::WordW-1:dzv_pkg::GroupW]};
        end
        if (step)
        begin
            byte_reg <= {more, z_reg[dzv_pkg::GroupW-1:0]};
            wd_reg   <= !more;
            bd_reg   <= !more && last_reg;
        end
    end

    assign out_valid      = ov_reg;
    assign out_byte       = byte_reg;
    assign out_word_done  = wd_reg;
    assign out_block_done = bd_reg;

    `DZV_ASSERT_SAME(a_done_matches_cont, clk, rst_n, ov_reg,
        wd_reg == !byte_reg[dzv_pkg::ByteW-1], "word end flag disagrees with byte")
    `DZV_ASSERT_SAME(a_block_implies_word, clk, rst_n, ov_reg && bd_reg,
        wd_reg, "block end on a byte that does not end its word")
    `DZV_ASSERT_NEXT(a_final_byte_frees, clk, rst_n, step && !more,
        !busy_reg && ov_reg && wd_reg, "final byte did not free the emitter")

endmodule

### hw/rtl/delta_zigzag_varint_encoder_top.sv
// Channel   Dir  tdata                 tuser          tlast
// s_axis    in   [63:0] word           -              last_in_block
// m_axis    out  [7:0] code_byte       [0] word_done  block_done
//
// A word is accepted in SUB_IDLE, run through the 8-bit serial subtractor, then held for handoff.
// The emitter sends one 7-bit group per cycle while m_axis_tready is high.
// Both stages overlap: the subtractor takes the next word while the emitter sends the last code.
// Reset clears the previous word to zero and empties both stages.
// A low m_axis_tready holds the output byte and in turn stalls both stages.
module delta_zigzag_varint_encoder_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [63:0] word
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] code_byte
    output logic        m_axis_tuser,   // [0] word_done
    output logic        m_axis_tlast
);

    logic                  diff_valid;
    logic                  diff_ready;
    dzv_pkg::diff_beat_t   diff_beat;

    dzv_delta u_delta
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_word    (s_axis_tdata),
        .in_last    (s_axis_tlast),
        .diff_valid (diff_valid),
        .diff_ready (diff_ready),
        .diff_beat  (diff_beat)
    );

    dzv_emit u_emit
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .diff_valid     (diff_valid),
        .diff_ready     (diff_ready),
        .diff_beat      (diff_beat),
        .out_valid      (m_axis_tvalid),
        .out_ready      (m_axis_tready),
        .out_byte       (m_axis_tdata),
        .out_word_done  (m_axis_tuser),
        .out_block_done (m_axis_tlast)
    );

endmodule

### verif/varint_code_checker.sv
module varint_code_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,
    input  logic        s_axis_tlast,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [7:0]  m_axis_tdata,
    input  logic        m_axis_tuser,
    input  logic        m_axis_tlast,
    output int unsigned mismatch_count,
    output int unsigned pending_code_beats
);

    typedef struct packed {
        logic [7:0] code_byte;
        logic       word_done;
        logic       block_done;
    } code_beat_t;

    code_beat_t  expected_code[$];
    logic [63:0] block_prev_word;

    initial
    begin
        mismatch_count     = 0;
        pending_code_beats = 0;
        block_prev_word    = 64'd0;
    end

    function automatic void encode_delta_varint(input logic [63:0] word, input logic closing);
        logic [63:0] delta;
        logic [63:0] mapped;
        code_beat_t  beat;
        logic        more;
        begin
            delta  = word - block_prev_word;
            mapped = {delta[62:0], 1'b0} ^ {64{delta[63]}};
            do
            begin
                beat.code_byte[6:0] = mapped[6:0];
                mapped              = mapped >> 7;
                more                = (mapped != 64'd0);
                beat.code_byte[7]   = more;
                beat.word_done      = !more;
                beat.block_done     = !more && closing;
                expected_code.push_back(beat);
            end
            while (more);
            block_prev_word = closing ? 64'd0 : word;
        end
    endfunction

    always @(posedge clk)
    begin
        code_beat_t want;
        if (!rst_n)
        begin
            block_prev_word = 64'd0;
        end
        else
        begin
            if (s_axis_tvalid === 1'b1 && s_axis_tready === 1'b1)
            begin
                encode_delta_varint(s_axis_tdata, s_axis_tlast);
            end
            if (m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1)
            begin
                if (expected_code.size() == 0)
                begin
                    $display("%0t: unexpected beat, expected none, actual byte %02h done %b last %b",
                             $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
                    mismatch_count <= mismatch_count + 1;
                end
                else
                begin
                    want = expected_code.pop_front();
                    if (m_axis_tdata !== want.code_byte || m_axis_tuser !== want.word_done
                        || m_axis_tlast !== want.block_done)
                    begin
                        $display("%0t: mismatch, expected byte %02h done %b last %b, actual byte %02h done %b last %b",
                                 $time, want.code_byte, want.word_done, want.block_done,
                                 m_axis_tdata, m_axis_tuser, m_axis_tlast);
                        mismatch_count <= mismatch_count + 1;
                    end
                end
            end
        end
        pending_code_beats <= expected_code.size();
    end

endmodule

### verif/delta_zigzag_varint_encoder_top_test.sv
module delta_zigzag_varint_encoder_top_test;

    localparam int unsigned CycleLimit = 400000;
    localparam int unsigned ItemsPerPhase = 90;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = 64'd0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tlast;

    int unsigned mismatch_count;
    int unsigned pending_code_beats;
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned cycle_count = 0;
    logic [63:0] stim_prev_word = 64'd0;

    always #6 clk = ~clk;

    delta_zigzag_varint_encoder_top dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    varint_code_checker code_check
    (
        .clk                (clk),
        .rst_n              (rst_n),
        .s_axis_tvalid      (s_axis_tvalid),
        .s_axis_tready      (s_axis_tready),
        .s_axis_tdata       (s_axis_tdata),
        .s_axis_tlast       (s_axis_tlast),
        .m_axis_tvalid      (m_axis_tvalid),
        .m_axis_tready      (m_axis_tready),
        .m_axis_tdata       (m_axis_tdata),
        .m_axis_tuser       (m_axis_tuser),
        .m_axis_tlast       (m_axis_tlast),
        .mismatch_count     (mismatch_count),
        .pending_code_beats (pending_code_beats)
    );

    always @(posedge clk)
    begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CycleLimit)
        begin
            $display("FAIL delta_zigzag_varint_encoder_top");
            $finish;
        end
    end

    task automatic send_word(input logic [63:0] word, input logic closing);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        s_axis_tlast  <= closing;
        @(posedge clk);
        while (s_axis_tready !== 1'b1)
        begin
            @(posedge clk);
        end
        stim_prev_word = closing ? 64'd0 : word;
    endtask

    task automatic drain_codes();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_code_beats != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Deltas of mostly random bit length so that every code length from 1 to 10 bytes shows up.
    task automatic send_random_word();
        logic [63:0] raw;
        logic [63:0] step;
        logic [63:0] word;
        int unsigned span;
        begin
            raw = {$urandom, $urandom};
            case ($urandom_range(9))
                0: word = raw;
                1: word = stim_prev_word ^ (64'd1 << $urandom_range(63));
                default:
                begin
                    span = $urandom_range(64);
                    step = (span == 0) ? 64'd0 : raw >> (64 - span);
                    word = $urandom_range(1) ? stim_prev_word + step : stim_prev_word - step;
                end
            endcase
            send_word(word, $urandom_range(7) == 0);
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_word(64'd0, 1'b0);
        send_word(64'd0, 1'b0);
        send_word(64'd1, 1'b0);
        send_word(64'd0, 1'b0);
        send_word(64'd64, 1'b0);
        send_word(64'd0, 1'b0);
        send_word(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        send_word(64'h7FFF_FFFF_FFFF_FFFF, 1'b0);
        send_word(64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
        send_word(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        send_word(64'h8000_0000_0000_0000, 1'b1);
        send_word(64'h7FFF_FFFF_FFFF_FFFF, 1'b1);
        send_word(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
        send_word(64'h5555_5555_5555_5555, 1'b1);
        send_word(64'h0123_4567_89AB_CDEF, 1'b1);
        send_word(64'd5, 1'b0);
        send_word(64'd5, 1'b0);
        send_word(64'h8000_0000_0000_0000, 1'b1);
        send_word(64'd8191, 1'b0);
        send_word(64'd0, 1'b1);

        send_idle_pct <= 18;
        recv_idle_pct <= 84;
        repeat (ItemsPerPhase) send_random_word();
        drain_codes();

        send_idle_pct <= 84;
        recv_idle_pct <= 18;
        repeat (ItemsPerPhase) send_random_word();
        drain_codes();

        send_idle_pct <= 0;
        recv_idle_pct <= 0;
        repeat (ItemsPerPhase) send_random_word();
        drain_codes();

        repeat (30) @(posedge clk);
        if (mismatch_count == 0 && pending_code_beats == 0)
        begin
            $display("PASS delta_zigzag_varint_encoder_top");
        end
        else
        begin
            $display("FAIL delta_zigzag_varint_encoder_top");
        end
        $finish;
    end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/dzv_pkg.sv
hw/rtl/dzv_delta.sv
hw/rtl/dzv_emit.sv
hw/rtl/delta_zigzag_varint_encoder_top.sv
verif/varint_code_checker.sv
verif/delta_zigzag_varint_encoder_top_test.sv
